// File: src/nljmc_pkg.sv
// Shared types and constants for the nested loop join match counter.
package nljmc_pkg;

  localparam int STORE_DEPTH_DEF = 1024;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int NUM_CELLS_DEF   = 8;

  localparam int CMD_W    = 2;
  localparam int KEY_IN_W = 32;
  localparam int COUNT_W  = 11;
  localparam int TOTAL_W  = 21;
  localparam int BATCH_W  = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
  localparam logic [BATCH_W-1:0] BATCH_RESET = BATCH_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_STORE = 2'd0,
    CMD_PROBE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Token that walks the cell chain alongside a row address.
  typedef struct packed {
    logic valid;
    logic last;
  } tok_t;

endpackage

// File: src/nljmc_ram.sv
// Generic single write port, single read port RAM with registered read data.
module nljmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/nljmc_cell.sv
// One chain cell: a bank of stored keys compared against the probe key as a row passes.
module nljmc_cell #(
  parameter int KEY_WIDTH = nljmc_pkg::KEY_WIDTH_DEF,
  parameter int NUM_CELLS = nljmc_pkg::NUM_CELLS_DEF,
  parameter int ROWS      = 128,
  parameter int LANE      = 0
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         wr_en,
  input  logic [(NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1)-1:0] wr_lane,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]     wr_row,
  input  logic [KEY_WIDTH-1:0]                         wr_key,
  input  logic [KEY_WIDTH-1:0]                         probe_key,
  input  logic [$clog2(ROWS+1)-1:0]                    fill_row,
  input  logic [(NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1)-1:0] fill_lane,
  input  nljmc_pkg::tok_t                              tok_in,
  input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]     row_in,
  input  logic [$clog2(NUM_CELLS+1)-1:0]               part_in,
  output nljmc_pkg::tok_t                              tok_out,
  output logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]     row_out,
  output logic [$clog2(NUM_CELLS+1)-1:0]               part_out
);

  localparam int RW  = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int LW  = NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1;
  localparam int FRW = $clog2(ROWS + 1);
  localparam int PW  = $clog2(NUM_CELLS + 1);

  nljmc_pkg::tok_t       tok_mid;
  logic [RW-1:0]         row_mid;
  logic [PW-1:0]         part_mid;
  logic [KEY_WIDTH-1:0]  rdata;
  logic                  entry_valid;
  logic                  hit;

  nljmc_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(ROWS)
  ) u_bank (
    .clk  (clk),
    .we   (wr_en && (wr_lane == LW'(LANE))),
    .waddr(wr_row),
    .wdata(wr_key),
    .raddr(row_in),
    .rdata(rdata)
  );

  // Full rows are all valid; the partially filled row holds lanes below fill_lane.
  assign entry_valid = (FRW'(row_mid) < fill_row) ||
                       ((FRW'(row_mid) == fill_row) && (LW'(LANE) < fill_lane));
  assign hit = tok_mid.valid && entry_valid && (rdata == probe_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_mid <= '0;
      tok_out <= '0;
    end else begin
      tok_mid <= tok_in;
      tok_out <= tok_mid;
    end
    row_mid  <= row_in;
    part_mid <= part_in;
    row_out  <= row_mid;
    part_out <= part_mid + PW'(hit);
  end

endmodule

// File: src/nested_loop_join_match_counter_unit.sv
// Top level: window key store spread over a chain of compare cells, with batch totals.
// Store, clear and unused commands pass from S_IDLE to S_OUT and on to the output register.
// Probe: S_SCAN issues the rows and S_FINISH folds the count into the batch state; an
// empty store skips S_SCAN. One row of NUM_CELLS keys enters the chain per cycle and each
// cell adds two register stages. One item is in work at a time; a finished result waits
// in the output register while the next item is accepted. Synchronous reset empties the
// store, clears batch state, sets the batch limit to 64; stored keys are not cleared.
module nested_loop_join_match_counter_unit #(
  parameter int STORE_DEPTH = nljmc_pkg::STORE_DEPTH_DEF,
  parameter int KEY_WIDTH   = nljmc_pkg::KEY_WIDTH_DEF,
  parameter int NUM_CELLS   = nljmc_pkg::NUM_CELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [nljmc_pkg::CMD_W-1:0]     cmd,
  input  logic [nljmc_pkg::KEY_IN_W-1:0]  join_key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [nljmc_pkg::COUNT_W-1:0]   match_count,
  output logic [nljmc_pkg::TOTAL_W-1:0]   batch_total,
  output logic                            batch_done,
  output logic                            store_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nljmc_pkg::BATCH_W-1:0]   batch_size
);

  localparam int ROWS = (STORE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;
  localparam int RW   = ROWS > 1 ? $clog2(ROWS) : 1;
  localparam int LW   = NUM_CELLS > 1 ? $clog2(NUM_CELLS) : 1;
  localparam int FRW  = $clog2(ROWS + 1);
  localparam int PW   = $clog2(NUM_CELLS + 1);
  localparam int FLW  = $clog2(STORE_DEPTH + 1);
  localparam int CW   = nljmc_pkg::COUNT_W;
  localparam int TW   = nljmc_pkg::TOTAL_W;
  localparam int BW   = nljmc_pkg::BATCH_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH, S_OUT} state_t;

  state_t                state;
  logic [FLW-1:0]        fill_level;
  logic [FRW-1:0]        fill_row;
  logic [LW-1:0]         fill_lane;
  logic [TW-1:0]         acc;
  logic [BW-1:0]         probes;
  logic [BW-1:0]         batch_limit;
  logic                  issuing;
  logic [RW-1:0]         row_ctr;
  logic [CW-1:0]         count;
  logic [KEY_WIDTH-1:0]  probe_key;
  logic [CW-1:0]         res_mc;
  logic [TW-1:0]         res_total;
  logic                  res_done;
  logic                  res_full;

  logic                  accept;
  logic                  is_full;
  logic                  wr_en;
  logic                  out_load;
  logic [FRW-1:0]        nrows;
  logic                  last_row;
  logic [CW:0]           count_sum;
  logic [CW-1:0]         count_next;
  logic [TW:0]           acc_wide;
  logic [TW-1:0]         acc_sum;
  logic                  done;

  nljmc_pkg::tok_t       tok  [NUM_CELLS+1];
  logic [RW-1:0]         row  [NUM_CELLS+1];
  logic [PW-1:0]         part [NUM_CELLS+1];

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign is_full   = (fill_level == FLW'(STORE_DEPTH));
  assign wr_en     = accept && (cmd == nljmc_pkg::CMD_STORE) && !is_full;
  // Hand the result over once the output register is free.
  assign out_load  = (state == S_OUT) && (!out_valid || !out_stall);

  assign nrows    = fill_row + FRW'(fill_lane != '0);
  assign last_row = ((FRW'(row_ctr) + FRW'(1)) == nrows);

  // Rows enter the chain from the sequencer.
  assign tok[0].valid = issuing;
  assign tok[0].last  = last_row;
  assign row[0]       = row_ctr;
  assign part[0]      = '0;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    nljmc_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .NUM_CELLS(NUM_CELLS),
      .ROWS     (ROWS),
      .LANE     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_lane  (fill_lane),
      .wr_row   (RW'(fill_row)),
      .wr_key   (KEY_WIDTH'(join_key)),
      .probe_key(probe_key),
      .fill_row (fill_row),
      .fill_lane(fill_lane),
      .tok_in   (tok[i]),
      .row_in   (row[i]),
      .part_in  (part[i]),
      .tok_out  (tok[i+1]),
      .row_out  (row[i+1]),
      .part_out (part[i+1])
    );
  end

  // Saturate the probe count and the batch total.
  assign count_sum  = {1'b0, count} + (CW+1)'(part[NUM_CELLS]);
  assign count_next = (count_sum > (CW+1)'(nljmc_pkg::COUNT_MAX)) ? nljmc_pkg::COUNT_MAX
                                                                 : count_sum[CW-1:0];
  assign acc_wide   = {1'b0, acc} + (TW+1)'(count);
  assign acc_sum    = (acc_wide > (TW+1)'(nljmc_pkg::TOTAL_MAX)) ? nljmc_pkg::TOTAL_MAX
                                                                : acc_wide[TW-1:0];
  assign done       = (({1'b0, probes} + (BW+1)'(1)) >= {1'b0, batch_limit});

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      fill_level  <= '0;
      fill_row    <= '0;
      fill_lane   <= '0;
      acc         <= '0;
      probes      <= '0;
      batch_limit <= nljmc_pkg::BATCH_RESET;
      issuing     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        batch_limit <= batch_size;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_mc    <= '0;
            res_total <= acc;
            res_done  <= 1'b0;
            res_full  <= (cmd == nljmc_pkg::CMD_STORE) && is_full;
            probe_key <= KEY_WIDTH'(join_key);
            unique case (nljmc_pkg::cmd_t'(cmd))
              nljmc_pkg::CMD_STORE: begin
                if (!is_full) begin
                  fill_level <= fill_level + FLW'(1);
                  if (fill_lane == LW'(NUM_CELLS - 1)) begin
                    fill_lane <= '0;
                    fill_row  <= fill_row + FRW'(1);
                  end else begin
                    fill_lane <= fill_lane + LW'(1);
                  end
                end
                state <= S_OUT;
              end
              nljmc_pkg::CMD_PROBE: begin
                count   <= '0;
                row_ctr <= '0;
                if (nrows == '0) begin
                  state <= S_FINISH;
                end else begin
                  issuing <= 1'b1;
                  state   <= S_SCAN;
                end
              end
              nljmc_pkg::CMD_CLEAR: begin
                fill_level <= '0;
                fill_row   <= '0;
                fill_lane  <= '0;
                state      <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            row_ctr <= row_ctr + RW'(1);
            if (last_row) begin
              issuing <= 1'b0;
            end
          end
          if (tok[NUM_CELLS].valid) begin
            count <= count_next;
            if (tok[NUM_CELLS].last) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          res_mc    <= count;
          res_total <= acc_sum;
          res_done  <= done;
          acc       <= done ? '0 : acc_sum;
          probes    <= done ? '0 : probes + BW'(1);
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            match_count <= res_mc;
            batch_total <= res_total;
            batch_done  <= res_done;
            store_full  <= res_full;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FLW'(STORE_DEPTH))
    else $error("fill level beyond store depth");

  a_fill_split: assert property (@(posedge clk) disable iff (rst)
    int'(fill_level) == int'(fill_row) * NUM_CELLS + int'(fill_lane))
    else $error("fill row and lane disagree with fill level");

  a_tail_scan: assert property (@(posedge clk) disable iff (rst)
    tok[NUM_CELLS].valid |-> (state == S_SCAN) && (FRW'(row[NUM_CELLS]) < nrows))
    else $error("chain output outside a probe scan");

  a_probe_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == nljmc_pkg::CMD_PROBE)) |=> (state == S_SCAN) || (state == S_FINISH))
    else $error("probe did not start a scan");

endmodule

// File: bench/tb_top.sv
// Testbench for the nested loop join match counter: directed and random transactions.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = nljmc_pkg::STORE_DEPTH_DEF;
  localparam int CMD_W = nljmc_pkg::CMD_W;
  localparam int KEY_IN_W = nljmc_pkg::KEY_IN_W;
  localparam int COUNT_W = nljmc_pkg::COUNT_W;
  localparam int TOTAL_W = nljmc_pkg::TOTAL_W;
  localparam int BATCH_W = nljmc_pkg::BATCH_W;
  localparam logic [CMD_W-1:0] CMD_STORE = nljmc_pkg::CMD_STORE;
  localparam logic [CMD_W-1:0] CMD_PROBE = nljmc_pkg::CMD_PROBE;
  localparam logic [CMD_W-1:0] CMD_CLEAR = nljmc_pkg::CMD_CLEAR;
  localparam int KEY_POOL_N = 6;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned TOTAL_SAT = (1 << TOTAL_W) - 1;
  localparam int unsigned COUNT_SAT = (1 << COUNT_W) - 1;

  typedef struct {
    logic [CMD_W-1:0]    op;
    logic [KEY_IN_W-1:0] key;
  } join_item_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic               done;
    logic               full;
  } join_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] cmd = CMD_STORE;
  logic [KEY_IN_W-1:0] join_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COUNT_W-1:0] match_count;
  logic [TOTAL_W-1:0] batch_total;
  logic batch_done;
  logic store_full;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [BATCH_W-1:0] batch_size = nljmc_pkg::BATCH_RESET;

  join_item_t   pending_items[$];
  join_result_t results_due[$];
  join_item_t   next_item;

  // predicted block state
  logic [KEY_IN_W-1:0] window_keys[WINDOW_DEPTH];
  int unsigned         window_fill = 0;
  int unsigned         batch_sum = 0;
  int unsigned         batch_probes = 0;
  logic [BATCH_W-1:0]  batch_limit = nljmc_pkg::BATCH_RESET;

  logic [KEY_IN_W-1:0] key_pool[KEY_POOL_N];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  nested_loop_join_match_counter_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .join_key    (join_key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .match_count (match_count),
    .batch_total (batch_total),
    .batch_done  (batch_done),
    .store_full  (store_full),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .batch_size  (batch_size)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void predict_join(input logic [CMD_W-1:0] op,
                                       input logic [KEY_IN_W-1:0] key);
    join_result_t r;
    int unsigned hits;
    r = '{count: '0, total: '0, done: 1'b0, full: 1'b0};
    case (op)
      CMD_STORE: begin
        if (window_fill < WINDOW_DEPTH) begin
          window_keys[window_fill] = key;
          window_fill++;
        end else begin
          r.full = 1'b1;
        end
      end
      CMD_PROBE: begin
        hits = 0;
        for (int i = 0; i < window_fill; i++)
          if (window_keys[i] == key) hits++;
        if (hits > COUNT_SAT) hits = COUNT_SAT;
        r.count = hits[COUNT_W-1:0];
        batch_sum = (batch_sum + hits > TOTAL_SAT) ? TOTAL_SAT : batch_sum + hits;
        batch_probes++;
        // a zero batch size behaves like one
        if (batch_probes >= batch_limit) r.done = 1'b1;
      end
      CMD_CLEAR: window_fill = 0;
      default: ;
    endcase
    r.total = batch_sum[TOTAL_W-1:0];
    results_due = {results_due, r};
    if (r.done) begin
      batch_sum = 0;
      batch_probes = 0;
    end
  endfunction

  // Driver: present queued items, hold while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_join(cmd, join_key);
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        cmd <= next_item.op;
        join_key <= next_item.key;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    join_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, count", match_count, 0);
        end else begin
          want = results_due.pop_front();
          if (match_count !== want.count) report_mismatch("match_count", match_count, want.count);
          if (batch_total !== want.total) report_mismatch("batch_total", batch_total, want.total);
          if (batch_done !== want.done) report_mismatch("batch_done", batch_done, want.done);
          if (store_full !== want.full) report_mismatch("store_full", store_full, want.full);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_item(input logic [CMD_W-1:0] op, input logic [KEY_IN_W-1:0] key);
    join_item_t item;
    item.op = op;
    item.key = key;
    pending_items = {pending_items, item};
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || results_due.size() != 0);
  endtask

  task automatic write_batch_size(input logic [BATCH_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    batch_size <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    batch_limit = value;
    @(negedge clk);
  endtask

  function automatic logic [KEY_IN_W-1:0] pick_key();
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(KEY_POOL_N-1)];
    return $urandom();
  endfunction

  task automatic add_random(input int n, input int clear_pct);
    int roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < clear_pct) add_item(CMD_CLEAR, $urandom());
      else if (roll < clear_pct + 3) add_item(CMD_UNUSED, $urandom());
      else if (roll < 45) add_item(CMD_STORE, pick_key());
      else add_item(CMD_PROBE, pick_key());
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    logic [KEY_IN_W-1:0] fill_key;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = $urandom();
    fill_key = $urandom();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset batch size, duplicates, extreme keys, unused command, clear
    set_idling(0, 0);
    add_item(CMD_PROBE, 32'h0000_0000);
    add_item(CMD_STORE, 32'h0000_0000);
    add_item(CMD_STORE, 32'hFFFF_FFFF);
    add_item(CMD_STORE, 32'h0000_0000);
    add_item(CMD_STORE, 32'h8000_0001);
    add_item(CMD_PROBE, 32'h0000_0000);
    add_item(CMD_PROBE, 32'hFFFF_FFFF);
    add_item(CMD_PROBE, 32'h0000_0007);
    add_item(CMD_UNUSED, 32'hA5A5_A5A5);
    add_item(CMD_CLEAR, 32'h5A5A_5A5A);
    add_item(CMD_PROBE, 32'h0000_0000);
    add_item(CMD_STORE, 32'h5A5A_5A5A);
    add_item(CMD_PROBE, 32'h5A5A_5A5A);
    wait_drained();
    // zero batch size: every probe closes a batch
    write_batch_size('0);
    add_item(CMD_PROBE, 32'h5A5A_5A5A);
    add_item(CMD_STORE, 32'h0000_0001);
    add_item(CMD_PROBE, 32'h0000_0001);
    wait_drained();
    write_batch_size('1);
    add_item(CMD_PROBE, 32'h5A5A_5A5A);
    add_item(CMD_PROBE, 32'h0000_0001);
    wait_drained();
    // shrink the batch below the open probe count
    write_batch_size(BATCH_W'(1));
    add_random(50, 5);
    wait_drained();

    // fill the window with one key, then overflow it
    write_batch_size(BATCH_W'(5));
    add_item(CMD_CLEAR, $urandom());
    for (int i = 0; i < WINDOW_DEPTH; i++) add_item(CMD_STORE, fill_key);
    add_item(CMD_STORE, ~fill_key);
    add_item(CMD_STORE, fill_key);
    add_item(CMD_PROBE, fill_key);
    add_item(CMD_PROBE, ~fill_key);
    add_item(CMD_UNUSED, fill_key);
    add_item(CMD_CLEAR, $urandom());
    add_item(CMD_PROBE, fill_key);
    wait_drained();

    set_idling(69, 0);
    write_batch_size(BATCH_W'(1024));
    add_random(70, 2);
    wait_drained();
    write_batch_size(BATCH_W'(7));
    add_random(70, 3);
    wait_drained();

    set_idling(0, 69);
    write_batch_size(BATCH_W'($urandom_range(20, 2)));
    add_random(80, 1);
    wait_drained();

    set_idling(33, 33);
    write_batch_size(BATCH_W'(64));
    add_random(80, 4);
    wait_drained();
    write_batch_size('0);
    add_random(20, 4);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
